// File: rtl/core/fru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fru_pkg
// Shared types, constants and value helpers of the float register stack unit.
// ----------------------------------------------------------------------------
package fru_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int PTR_W       = 3;
  localparam int SIG_W       = 64;
  localparam int SE_W        = 16;
  localparam int ENTRY_W     = SE_W + SIG_W;
  localparam int TAG_W       = 2;
  localparam int WORD_W      = 16;
  localparam int FLAG_W      = 3;
  localparam int TOP_LSB     = 11;

  localparam logic [SE_W-1:0]   EXP_MASK  = 16'h7FFF;
  localparam logic [SE_W-1:0]   SIGN_BIT  = 16'h8000;
  localparam logic [WORD_W-1:0] TOP_FIELD = 16'h3800;
  localparam logic [WORD_W-1:0] BIT_C0    = 16'h0100;
  localparam logic [WORD_W-1:0] BIT_C1    = 16'h0200;
  localparam logic [WORD_W-1:0] BIT_C2    = 16'h0400;
  localparam logic [WORD_W-1:0] BIT_C3    = 16'h4000;
  localparam logic [WORD_W-1:0] CLEX_KEEP = 16'h7F00;
  localparam logic [SIG_W-1:0]  FRAC_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [TAG_W-1:0] KIND_VALID   = 2'd0;
  localparam logic [TAG_W-1:0] KIND_ZERO    = 2'd1;
  localparam logic [TAG_W-1:0] KIND_SPECIAL = 2'd2;
  localparam logic [TAG_W-1:0] KIND_EMPTY   = 2'd3;

  // compare_flags codes: bit0 CF, bit1 PF, bit2 ZF
  localparam logic [FLAG_W-1:0] CMPF_GT = 3'd0;
  localparam logic [FLAG_W-1:0] CMPF_LT = 3'd1;
  localparam logic [FLAG_W-1:0] CMPF_EQ = 3'd4;
  localparam logic [FLAG_W-1:0] CMPF_UN = 3'd7;

  typedef enum logic [4:0] {
    OP_INIT  = 5'd0,
    OP_PUSH  = 5'd1,
    OP_POP   = 5'd2,
    OP_XCH   = 5'd3,
    OP_COPY  = 5'd4,
    OP_FREE  = 5'd5,
    OP_INC   = 5'd6,
    OP_DEC   = 5'd7,
    OP_COM   = 5'd8,
    OP_COMI  = 5'd9,
    OP_TST   = 5'd10,
    OP_XAM   = 5'd11,
    OP_CHS   = 5'd12,
    OP_ABS   = 5'd13,
    OP_READ  = 5'd14,
    OP_WORDS = 5'd15,
    OP_WSW   = 5'd16,
    OP_WTAG  = 5'd17,
    OP_CLEX  = 5'd18
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    CMP_GT,
    CMP_LT,
    CMP_EQ,
    CMP_UN
  } cmp_t;

  // stored tag plus value class bits kept beside the register memory
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             zf;
    logic             sf;
  } ent_t;

  typedef struct packed {
    logic              clear_all;
    logic              load_word;
    logic [WORD_W-1:0] word;
    logic              wa_en;
    logic [PTR_W-1:0]  wa_addr;
    ent_t              wa_ent;
    logic              wb_en;
    logic [PTR_W-1:0]  wb_addr;
    ent_t              wb_ent;
  } tag_cmd_t;

  function automatic logic is_zero(input logic [SIG_W-1:0] sg, input logic [SE_W-1:0] se);
    return ((se & EXP_MASK) == '0) && (sg == '0);
  endfunction

  function automatic logic is_special(input logic [SE_W-1:0] se);
    return (se & EXP_MASK) == EXP_MASK;
  endfunction

  function automatic logic is_nan(input logic [SIG_W-1:0] sg, input logic [SE_W-1:0] se);
    return is_special(se) && ((sg & FRAC_MASK) != '0);
  endfunction

  function automatic logic is_inf(input logic [SIG_W-1:0] sg, input logic [SE_W-1:0] se);
    return is_special(se) && ((sg & FRAC_MASK) == '0);
  endfunction

  function automatic logic [TAG_W-1:0] classify(input ent_t e);
    logic [TAG_W-1:0] t;
    t = e.tag;
    if (e.tag != KIND_EMPTY) begin
      if (e.zf) begin
        t = KIND_ZERO;
      end else if (e.sf) begin
        t = KIND_SPECIAL;
      end
    end
    return t;
  endfunction

  function automatic cmp_t compare(
    input logic [SIG_W-1:0] as_, input logic [SE_W-1:0] ae, input logic a_empty,
    input logic [SIG_W-1:0] bs,  input logic [SE_W-1:0] be, input logic b_empty
  );
    logic sa;
    logic sb;
    logic mag_lt;
    cmp_t r;
    sa     = ae[SE_W-1];
    sb     = be[SE_W-1];
    mag_lt = (ae < be) || ((ae == be) && (as_ < bs));
    if (a_empty || b_empty || is_nan(as_, ae) || is_nan(bs, be)) begin
      r = CMP_UN;
    end else if ((as_ == bs) &&
                 ((ae == be) || ((as_ == '0) && (((ae | be) & EXP_MASK) == '0)))) begin
      r = CMP_EQ;
    end else if (sa != sb) begin
      r = sa ? CMP_LT : CMP_GT;
    end else begin
      r = (sa != mag_lt) ? CMP_LT : CMP_GT;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/fru_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fru_in_if
// Request channel: opcode, stack index and operand payload.
// ----------------------------------------------------------------------------
interface fru_in_if;
  logic                          valid;
  logic                          ready;
  logic [4:0]                    opcode;
  logic [fru_pkg::PTR_W-1:0]     index;
  logic [fru_pkg::SIG_W-1:0]     value_significand;
  logic [fru_pkg::SE_W-1:0]      value_sign_exp;
  logic [fru_pkg::WORD_W-1:0]    word_value;

  modport source (
    output valid, opcode, index, value_significand, value_sign_exp, word_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, index, value_significand, value_sign_exp, word_value,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/fru_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fru_out_if
// Result channel: read value, tags, status word and compare flags.
// ----------------------------------------------------------------------------
interface fru_out_if;
  logic                          valid;
  logic                          ready;
  logic [fru_pkg::SIG_W-1:0]     out_significand;
  logic [fru_pkg::SE_W-1:0]      out_sign_exp;
  logic [fru_pkg::TAG_W-1:0]     out_tag;
  logic [fru_pkg::WORD_W-1:0]    status_out;
  logic [fru_pkg::WORD_W-1:0]    tag_word_out;
  logic [fru_pkg::FLAG_W-1:0]    compare_flags;

  modport source (
    output valid, out_significand, out_sign_exp, out_tag, status_out, tag_word_out,
           compare_flags,
    input  ready
  );
  modport sink (
    input  valid, out_significand, out_sign_exp, out_tag, status_out, tag_word_out,
           compare_flags,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/float_register_stack_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float_register_stack_unit
// Eight-entry 80-bit register stack with top pointer, tags and status word.
// ----------------------------------------------------------------------------
// req carries one opcode per transfer with its stack index and operands; rsp
// returns exactly one result per request: st(index) for a read, the classified
// tag of st(index), the status word with the top pointer in bits 13..11, the
// classified tag word and the CF/PF/ZF compare flags.
// One request is in work at a time. The transfer edge issues both operand
// reads, st(0) and st(index), to the register memory; the EXEC state then
// updates state and writes back, and the FIN state loads the result register
// once the result register is free. An exchange passes through the SWAP state
// between them for its second write on the single write port. A new request
// is taken only after the result is loaded and the unit is idle again.
// A stalled rsp holds the result register; the unit then waits with the next
// result finished until the register frees.
// Reset empties all tags, clears top pointer, status and result valid, and
// makes every memory entry read as zero until it is next written.
// ----------------------------------------------------------------------------
module float_register_stack_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  fru_in_if.sink     req,
  fru_out_if.source  rsp
);

  fru_pkg::state_t                 state;
  fru_pkg::state_t                 state_next;
  fru_pkg::op_t                    op_q;
  logic [fru_pkg::PTR_W-1:0]       idx_q;
  logic [fru_pkg::SIG_W-1:0]       vsig_q;
  logic [fru_pkg::SE_W-1:0]        vse_q;
  logic [fru_pkg::WORD_W-1:0]      word_q;
  logic [fru_pkg::PTR_W-1:0]       top;
  logic [fru_pkg::PTR_W-1:0]       top_next;
  logic [fru_pkg::WORD_W-1:0]      status;
  logic [fru_pkg::WORD_W-1:0]      status_next;
  logic [fru_pkg::FLAG_W-1:0]      flags;
  logic [fru_pkg::FLAG_W-1:0]      flags_next;
  logic                            out_valid;
  logic                            load_out;
  logic                            accept;

  logic                            re;
  logic                            we;
  logic [fru_pkg::PTR_W-1:0]       waddr;
  logic [fru_pkg::ENTRY_W-1:0]     wdata;
  logic [fru_pkg::ENTRY_W-1:0]     rdata_a;
  logic [fru_pkg::ENTRY_W-1:0]     rdata_b;
  logic [fru_pkg::PTR_W-1:0]       o_addr;
  logic [fru_pkg::PTR_W-1:0]       top_m1;
  logic [fru_pkg::PTR_W-1:0]       top_p1;

  fru_pkg::tag_cmd_t               tcmd;
  fru_pkg::ent_t                   qa;
  fru_pkg::ent_t                   qb;
  logic [fru_pkg::WORD_W-1:0]      tag_word;

  logic [fru_pkg::SIG_W-1:0]       a_sig;
  logic [fru_pkg::SE_W-1:0]        a_se;
  logic [fru_pkg::SIG_W-1:0]       b_sig;
  logic [fru_pkg::SE_W-1:0]        b_se;
  logic                            b_empty;
  fru_pkg::cmp_t                   cmp;

  function automatic logic [fru_pkg::WORD_W-1:0] with_c320(
    input logic [fru_pkg::WORD_W-1:0] sw, input logic c3, input logic c2, input logic c0
  );
    logic [fru_pkg::WORD_W-1:0] r;
    r = sw & ~(fru_pkg::BIT_C3 | fru_pkg::BIT_C2 | fru_pkg::BIT_C0);
    if (c3) r = r | fru_pkg::BIT_C3;
    if (c2) r = r | fru_pkg::BIT_C2;
    if (c0) r = r | fru_pkg::BIT_C0;
    return r;
  endfunction

  assign accept = req.valid && req.ready;
  assign o_addr = top + idx_q;
  assign top_m1 = top - fru_pkg::PTR_W'(1);
  assign top_p1 = top + fru_pkg::PTR_W'(1);

  fru_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .re      (re),
    .raddr_a (top),
    .raddr_b (top + req.index),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // qb follows st(index) against the current top, so in the final cycle it
  // already sees the updated pointer
  fru_tagfile u_tagfile (
    .clk      (clk),
    .rst      (rst),
    .cmd      (tcmd),
    .qa_addr  (top),
    .qb_addr  (o_addr),
    .qa       (qa),
    .qb       (qb),
    .tag_word (tag_word)
  );

  assign a_sig   = rdata_a[fru_pkg::SIG_W-1:0];
  assign a_se    = rdata_a[fru_pkg::ENTRY_W-1:fru_pkg::SIG_W];
  // tst compares st(0) with +0
  assign b_sig   = (op_q == fru_pkg::OP_TST) ? '0 : rdata_b[fru_pkg::SIG_W-1:0];
  assign b_se    = (op_q == fru_pkg::OP_TST) ? '0 : rdata_b[fru_pkg::ENTRY_W-1:fru_pkg::SIG_W];
  assign b_empty = (op_q != fru_pkg::OP_TST) && (qb.tag == fru_pkg::KIND_EMPTY);
  assign cmp     = fru_pkg::compare(a_sig, a_se, qa.tag == fru_pkg::KIND_EMPTY,
                                    b_sig, b_se, b_empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fru_pkg::S_IDLE;
      top       <= '0;
      status    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      top    <= top_next;
      status <= status_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= fru_pkg::op_t'(req.opcode);
      idx_q  <= req.index;
      vsig_q <= req.value_significand;
      vse_q  <= req.value_sign_exp;
      word_q <= req.word_value;
    end
    flags <= flags_next;
    if (load_out) begin
      rsp.out_significand <= (op_q == fru_pkg::OP_READ) ? rdata_b[fru_pkg::SIG_W-1:0] : '0;
      rsp.out_sign_exp    <= (op_q == fru_pkg::OP_READ) ?
                             rdata_b[fru_pkg::ENTRY_W-1:fru_pkg::SIG_W] : '0;
      rsp.out_tag         <= fru_pkg::classify(qb);
      rsp.status_out      <= (status & ~fru_pkg::TOP_FIELD) |
                             (fru_pkg::WORD_W'(top) << fru_pkg::TOP_LSB);
      rsp.tag_word_out    <= tag_word;
      rsp.compare_flags   <= flags;
    end
  end

  assign rsp.valid = out_valid;
  assign req.ready = (state == fru_pkg::S_IDLE);

  always_comb begin
    state_next  = state;
    top_next    = top;
    status_next = status;
    flags_next  = flags;
    load_out    = 1'b0;
    re          = 1'b0;
    we          = 1'b0;
    waddr       = top;
    wdata       = rdata_a;
    tcmd        = '0;
    tcmd.word   = word_q;

    case (state)
      fru_pkg::S_IDLE: begin
        if (req.valid) begin
          re         = 1'b1;
          state_next = fru_pkg::S_EXEC;
        end
      end

      fru_pkg::S_EXEC: begin
        state_next = fru_pkg::S_FIN;
        flags_next = fru_pkg::CMPF_GT;
        case (op_q)
          fru_pkg::OP_INIT: begin
            status_next    = '0;
            top_next       = '0;
            tcmd.clear_all = 1'b1;
          end
          fru_pkg::OP_PUSH: begin
            top_next        = top_m1;
            we              = 1'b1;
            waddr           = top_m1;
            wdata           = {vse_q, vsig_q};
            tcmd.wa_en      = 1'b1;
            tcmd.wa_addr    = top_m1;
            tcmd.wa_ent.tag = fru_pkg::KIND_VALID;
            tcmd.wa_ent.zf  = fru_pkg::is_zero(vsig_q, vse_q);
            tcmd.wa_ent.sf  = fru_pkg::is_special(vse_q);
          end
          fru_pkg::OP_POP: begin
            tcmd.wa_en      = 1'b1;
            tcmd.wa_addr    = top;
            tcmd.wa_ent     = qa;
            tcmd.wa_ent.tag = fru_pkg::KIND_EMPTY;
            top_next        = top_p1;
          end
          fru_pkg::OP_XCH: begin
            // st(0) goes to st(i) now, st(i) goes to st(0) in the next cycle
            we           = 1'b1;
            waddr        = o_addr;
            wdata        = rdata_a;
            tcmd.wa_en   = 1'b1;
            tcmd.wa_addr = o_addr;
            tcmd.wa_ent  = qa;
            tcmd.wb_en   = 1'b1;
            tcmd.wb_addr = top;
            tcmd.wb_ent  = qb;
            state_next   = fru_pkg::S_SWAP;
          end
          fru_pkg::OP_COPY: begin
            we           = 1'b1;
            waddr        = o_addr;
            wdata        = rdata_a;
            tcmd.wa_en   = 1'b1;
            tcmd.wa_addr = o_addr;
            tcmd.wa_ent  = qa;
          end
          fru_pkg::OP_FREE: begin
            tcmd.wa_en      = 1'b1;
            tcmd.wa_addr    = o_addr;
            tcmd.wa_ent     = qb;
            tcmd.wa_ent.tag = fru_pkg::KIND_EMPTY;
          end
          fru_pkg::OP_INC: begin
            top_next = top_p1;
          end
          fru_pkg::OP_DEC: begin
            top_next = top_m1;
          end
          fru_pkg::OP_COM,
          fru_pkg::OP_TST: begin
            status_next = with_c320(status,
                                    (cmp == fru_pkg::CMP_EQ) || (cmp == fru_pkg::CMP_UN),
                                    cmp == fru_pkg::CMP_UN,
                                    (cmp == fru_pkg::CMP_LT) || (cmp == fru_pkg::CMP_UN));
          end
          fru_pkg::OP_COMI: begin
            case (cmp)
              fru_pkg::CMP_UN: flags_next = fru_pkg::CMPF_UN;
              fru_pkg::CMP_EQ: flags_next = fru_pkg::CMPF_EQ;
              fru_pkg::CMP_LT: flags_next = fru_pkg::CMPF_LT;
              default:         flags_next = fru_pkg::CMPF_GT;
            endcase
          end
          fru_pkg::OP_XAM: begin
            status_next = status & ~fru_pkg::BIT_C1;
            if (a_se[fru_pkg::SE_W-1]) begin
              status_next = status_next | fru_pkg::BIT_C1;
            end
            if (qa.tag == fru_pkg::KIND_EMPTY) begin
              status_next = with_c320(status_next, 1'b1, 1'b0, 1'b1);
            end else if (fru_pkg::is_nan(a_sig, a_se)) begin
              status_next = with_c320(status_next, 1'b0, 1'b0, 1'b1);
            end else if (fru_pkg::is_inf(a_sig, a_se)) begin
              status_next = with_c320(status_next, 1'b0, 1'b1, 1'b1);
            end else if (fru_pkg::is_zero(a_sig, a_se)) begin
              status_next = with_c320(status_next, 1'b1, 1'b0, 1'b0);
            end else begin
              status_next = with_c320(status_next, 1'b0, 1'b1, 1'b0);
            end
          end
          fru_pkg::OP_CHS: begin
            we          = 1'b1;
            waddr       = top;
            wdata       = {a_se ^ fru_pkg::SIGN_BIT, a_sig};
            status_next = status & ~fru_pkg::BIT_C1;
          end
          fru_pkg::OP_ABS: begin
            we          = 1'b1;
            waddr       = top;
            wdata       = {a_se & fru_pkg::EXP_MASK, a_sig};
            status_next = status & ~fru_pkg::BIT_C1;
          end
          fru_pkg::OP_WSW: begin
            status_next = word_q;
            top_next    = word_q[fru_pkg::TOP_LSB +: fru_pkg::PTR_W];
          end
          fru_pkg::OP_WTAG: begin
            tcmd.load_word = 1'b1;
          end
          fru_pkg::OP_CLEX: begin
            status_next = status & fru_pkg::CLEX_KEEP;
          end
          default: begin
          end
        endcase
      end

      fru_pkg::S_SWAP: begin
        we         = 1'b1;
        waddr      = top;
        wdata      = rdata_b;
        state_next = fru_pkg::S_FIN;
      end

      fru_pkg::S_FIN: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = fru_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = fru_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/fru_regfile.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fru_regfile
// 8 x 80-bit register memory, one write port, two registered read ports.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module fru_regfile (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           re,
  input  wire logic [fru_pkg::PTR_W-1:0]      raddr_a,
  input  wire logic [fru_pkg::PTR_W-1:0]      raddr_b,
  input  wire logic                           we,
  input  wire logic [fru_pkg::PTR_W-1:0]      waddr,
  input  wire logic [fru_pkg::ENTRY_W-1:0]    wdata,
  output logic      [fru_pkg::ENTRY_W-1:0]    rdata_a,
  output logic      [fru_pkg::ENTRY_W-1:0]    rdata_b
);

  logic [fru_pkg::ENTRY_W-1:0]     mem [fru_pkg::NUM_ENTRIES];
  logic [fru_pkg::NUM_ENTRIES-1:0] written;
  logic [fru_pkg::ENTRY_W-1:0]     rd_a;
  logic [fru_pkg::ENTRY_W-1:0]     rd_b;
  logic                            rv_a;
  logic                            rv_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a <= mem[raddr_a];
      rd_b <= mem[raddr_b];
      rv_a <= written[raddr_a];
      rv_b <= written[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  assign rdata_a = rv_a ? rd_a : '0;
  assign rdata_b = rv_b ? rd_b : '0;

endmodule
`default_nettype wire

// File: rtl/core/fru_tagfile.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fru_tagfile
// Per-entry tags and value class bits, with the classified tag word.
// ----------------------------------------------------------------------------
module fru_tagfile (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire fru_pkg::tag_cmd_t            cmd,
  input  wire logic [fru_pkg::PTR_W-1:0]    qa_addr,
  input  wire logic [fru_pkg::PTR_W-1:0]    qb_addr,
  output fru_pkg::ent_t                     qa,
  output fru_pkg::ent_t                     qb,
  output logic      [fru_pkg::WORD_W-1:0]   tag_word
);

  fru_pkg::ent_t ents [fru_pkg::NUM_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fru_pkg::NUM_ENTRIES; i++) begin
        ents[i].tag <= fru_pkg::KIND_EMPTY;
        ents[i].zf  <= 1'b1;   // contents reset to zero
        ents[i].sf  <= 1'b0;
      end
    end else if (cmd.clear_all) begin
      for (int i = 0; i < fru_pkg::NUM_ENTRIES; i++) begin
        ents[i].tag <= fru_pkg::KIND_EMPTY;
      end
    end else if (cmd.load_word) begin
      for (int i = 0; i < fru_pkg::NUM_ENTRIES; i++) begin
        ents[i].tag <= cmd.word[fru_pkg::TAG_W*i +: fru_pkg::TAG_W];
      end
    end else begin
      if (cmd.wa_en) begin
        ents[cmd.wa_addr] <= cmd.wa_ent;
      end
      if (cmd.wb_en) begin
        ents[cmd.wb_addr] <= cmd.wb_ent;
      end
    end
  end

  assign qa = ents[qa_addr];
  assign qb = ents[qb_addr];

  for (genvar g = 0; g < fru_pkg::NUM_ENTRIES; g++) begin : g_tw
    assign tag_word[fru_pkg::TAG_W*g +: fru_pkg::TAG_W] = fru_pkg::classify(ents[g]);
  end

endmodule
`default_nettype wire

// File: rtl/core/fru_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fru_checker
// Port-level checks on the float register stack unit, bound to the top.
// ----------------------------------------------------------------------------
module fru_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           req_valid,
  input wire logic                           req_ready,
  input wire logic                           rsp_valid,
  input wire logic                           rsp_ready,
  input wire logic [fru_pkg::WORD_W-1:0]     status_out,
  input wire logic [fru_pkg::WORD_W-1:0]     tag_word_out,
  input wire logic [fru_pkg::FLAG_W-1:0]     compare_flags
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(status_out) && $stable(tag_word_out)
                                && $stable(compare_flags))
    else $error("rsp payload changed while stalled");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while one is in work");

  a_flag_codes: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (compare_flags == fru_pkg::CMPF_GT) || (compare_flags == fru_pkg::CMPF_LT) ||
                  (compare_flags == fru_pkg::CMPF_EQ) || (compare_flags == fru_pkg::CMPF_UN))
    else $error("compare flags hold an impossible code");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result offered right after reset");

endmodule

bind float_register_stack_unit fru_checker u_fru_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status_out    (rsp.status_out),
  .tag_word_out  (rsp.tag_word_out),
  .compare_flags (rsp.compare_flags)
);
`default_nettype wire

// File: test/fru_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_stack_checker
// Follows every request transfer of the float register stack unit, keeps its
// own copy of the stack, tags, top pointer and status word, and compares each
// result transfer field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module fru_stack_checker
  import fru_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  logic [4:0]        req_opcode,
  input  logic [PTR_W-1:0]  req_index,
  input  logic [SIG_W-1:0]  req_sig,
  input  logic [SE_W-1:0]   req_se,
  input  logic [WORD_W-1:0] req_word,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  logic [SIG_W-1:0]  rsp_sig,
  input  logic [SE_W-1:0]   rsp_se,
  input  logic [TAG_W-1:0]  rsp_tag,
  input  logic [WORD_W-1:0] rsp_status,
  input  logic [WORD_W-1:0] rsp_tag_word,
  input  logic [FLAG_W-1:0] rsp_flags,
  output int                errors,
  output int                outstanding
);

  typedef struct packed {
    logic [SIG_W-1:0]  sig;
    logic [SE_W-1:0]   se;
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] status;
    logic [WORD_W-1:0] tag_word;
    logic [FLAG_W-1:0] flags;
  } stack_view_t;

  logic [SIG_W-1:0]  reg_sig [NUM_ENTRIES];
  logic [SE_W-1:0]   reg_se  [NUM_ENTRIES];
  logic [TAG_W-1:0]  reg_tag [NUM_ENTRIES];
  logic [PTR_W-1:0]  top_ptr;
  logic [WORD_W-1:0] stat_word;
  stack_view_t       view_q [$];
  int                fail_count = 0;

  function automatic logic holds_nan(input logic [SIG_W-1:0] sig, input logic [SE_W-1:0] se);
    return ((se & EXP_MASK) == EXP_MASK) && ((sig & FRAC_MASK) != '0);
  endfunction

  function automatic logic holds_zero(input logic [SIG_W-1:0] sig, input logic [SE_W-1:0] se);
    return ((se & EXP_MASK) == '0) && (sig == '0);
  endfunction

  // stored tag, overridden by the value's class unless the entry is empty
  function automatic logic [TAG_W-1:0] shown_tag(input logic [PTR_W-1:0] p);
    logic [TAG_W-1:0] t;
    t = reg_tag[p];
    if (t != KIND_EMPTY) begin
      if (holds_zero(reg_sig[p], reg_se[p])) begin
        t = KIND_ZERO;
      end else if ((reg_se[p] & EXP_MASK) == EXP_MASK) begin
        t = KIND_SPECIAL;
      end
    end
    return t;
  endfunction

  function automatic cmp_t order_of(
    input logic [SIG_W-1:0] a_sig, input logic [SE_W-1:0] a_se, input logic a_out,
    input logic [SIG_W-1:0] b_sig, input logic [SE_W-1:0] b_se, input logic b_out
  );
    logic mag_lt;
    mag_lt = (a_se < b_se) || ((a_se == b_se) && (a_sig < b_sig));
    if (a_out || b_out || holds_nan(a_sig, a_se) || holds_nan(b_sig, b_se)) begin
      return CMP_UN;
    end
    // +0 and -0 are equal
    if ((a_sig == b_sig) &&
        ((a_se == b_se) || ((a_sig == '0) && (((a_se | b_se) & EXP_MASK) == '0)))) begin
      return CMP_EQ;
    end
    if (a_se[SE_W-1] != b_se[SE_W-1]) begin
      return a_se[SE_W-1] ? CMP_LT : CMP_GT;
    end
    return (a_se[SE_W-1] != mag_lt) ? CMP_LT : CMP_GT;
  endfunction

  function automatic void set_cond(input logic [WORD_W-1:0] bits, input logic on);
    stat_word = on ? (stat_word | bits) : (stat_word & ~bits);
  endfunction

  function automatic void set_cc(input logic c3, input logic c2, input logic c0);
    set_cond(BIT_C3, c3);
    set_cond(BIT_C2, c2);
    set_cond(BIT_C0, c0);
  endfunction

  function automatic stack_view_t run_op(
    input logic [4:0]        opc,
    input logic [PTR_W-1:0]  idx,
    input logic [SIG_W-1:0]  vsig,
    input logic [SE_W-1:0]   vse,
    input logic [WORD_W-1:0] word
  );
    stack_view_t      v;
    logic [PTR_W-1:0] t;
    logic [PTR_W-1:0] o;
    logic [SIG_W-1:0] b_sig;
    logic [SE_W-1:0]  b_se;
    logic             b_out;
    logic [SIG_W-1:0] hold_sig;
    logic [SE_W-1:0]  hold_se;
    logic [TAG_W-1:0] hold_tag;
    cmp_t             ord;
    v = '0;
    t = top_ptr;
    o = t + idx;
    // test compares against +0, the other compares against st(i)
    if (opc == OP_TST) begin
      b_sig = '0;
      b_se  = '0;
      b_out = 1'b0;
    end else begin
      b_sig = reg_sig[o];
      b_se  = reg_se[o];
      b_out = (shown_tag(o) == KIND_EMPTY);
    end
    ord = order_of(reg_sig[t], reg_se[t], shown_tag(t) == KIND_EMPTY, b_sig, b_se, b_out);
    case (opc)
      OP_INIT: begin
        stat_word = '0;
        top_ptr   = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          reg_tag[i] = KIND_EMPTY;
        end
      end
      OP_PUSH: begin
        t          = t - 1'b1;
        top_ptr    = t;
        reg_tag[t] = KIND_VALID;
        reg_sig[t] = vsig;
        reg_se[t]  = vse;
      end
      OP_POP: begin
        reg_tag[t] = KIND_EMPTY;
        top_ptr    = t + 1'b1;
      end
      OP_XCH: begin
        hold_tag   = reg_tag[o];
        hold_sig   = reg_sig[o];
        hold_se    = reg_se[o];
        reg_tag[o] = reg_tag[t];
        reg_sig[o] = reg_sig[t];
        reg_se[o]  = reg_se[t];
        reg_tag[t] = hold_tag;
        reg_sig[t] = hold_sig;
        reg_se[t]  = hold_se;
      end
      OP_COPY: begin
        reg_tag[o] = reg_tag[t];
        reg_sig[o] = reg_sig[t];
        reg_se[o]  = reg_se[t];
      end
      OP_FREE: reg_tag[o] = KIND_EMPTY;
      OP_INC:  top_ptr = t + 1'b1;
      OP_DEC:  top_ptr = t - 1'b1;
      OP_COM, OP_TST: begin
        set_cc(ord == CMP_EQ || ord == CMP_UN, ord == CMP_UN, ord == CMP_LT || ord == CMP_UN);
      end
      OP_COMI: begin
        case (ord)
          CMP_UN:  v.flags = CMPF_UN;
          CMP_EQ:  v.flags = CMPF_EQ;
          CMP_LT:  v.flags = CMPF_LT;
          default: v.flags = CMPF_GT;
        endcase
      end
      OP_XAM: begin
        set_cond(BIT_C1, reg_se[t][SE_W-1]);
        if (reg_tag[t] == KIND_EMPTY) begin
          set_cc(1'b1, 1'b0, 1'b1);
        end else if (holds_nan(reg_sig[t], reg_se[t])) begin
          set_cc(1'b0, 1'b0, 1'b1);
        end else if ((reg_se[t] & EXP_MASK) == EXP_MASK) begin
          set_cc(1'b0, 1'b1, 1'b1);
        end else if (holds_zero(reg_sig[t], reg_se[t])) begin
          set_cc(1'b1, 1'b0, 1'b0);
        end else begin
          set_cc(1'b0, 1'b1, 1'b0);
        end
      end
      OP_CHS: begin
        reg_se[t] = reg_se[t] ^ SIGN_BIT;
        set_cond(BIT_C1, 1'b0);
      end
      OP_ABS: begin
        reg_se[t] = reg_se[t] & EXP_MASK;
        set_cond(BIT_C1, 1'b0);
      end
      OP_READ: begin
        v.sig = reg_sig[o];
        v.se  = reg_se[o];
      end
      OP_WSW: begin
        stat_word = word;
        top_ptr   = word[TOP_LSB +: PTR_W];
      end
      OP_WTAG: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          reg_tag[i] = word[TAG_W*i +: TAG_W];
        end
      end
      OP_CLEX: stat_word = stat_word & CLEX_KEEP;
      default: ;
    endcase
    t        = top_ptr;
    o        = t + idx;
    v.tag    = shown_tag(o);
    v.status = (stat_word & ~TOP_FIELD) | (WORD_W'(t) << TOP_LSB);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      v.tag_word[TAG_W*i +: TAG_W] = shown_tag(PTR_W'(i));
    end
    return v;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s differs, expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    stack_view_t want;
    stack_view_t got;
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        reg_sig[i] = '0;
        reg_se[i]  = '0;
        reg_tag[i] = KIND_EMPTY;
      end
      top_ptr   = '0;
      stat_word = '0;
      view_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        got = {rsp_sig, rsp_se, rsp_tag, rsp_status, rsp_tag_word, rsp_flags};
        if (view_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = view_q.pop_front();
          check_field("out_significand", want.sig, got.sig);
          check_field("out_sign_exp", want.se, got.se);
          check_field("out_tag", want.tag, got.tag);
          check_field("status_out", want.status, got.status);
          check_field("tag_word_out", want.tag_word, got.tag_word);
          check_field("compare_flags", want.flags, got.flags);
        end
      end
      if (req_valid && req_ready) begin
        view_q.push_back(run_op(req_opcode, req_index, req_sig, req_se, req_word));
      end
    end
    errors      <= fail_count;
    outstanding <= view_q.size();
  end

endmodule

// File: test/float_register_stack_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_register_stack_unit_tb
// Drives a directed opening sequence and then randomly weighted stack
// instructions into the unit, with bursty requests and a stalling result
// side; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module float_register_stack_unit_tb;
  import fru_pkg::*;

  localparam logic [4:0] OP_SPARE_LO  = 5'd19;
  localparam logic [4:0] OP_SPARE_HI  = 5'd31;
  localparam int         RANDOM_ITEMS = 1030;
  localparam int         DRAIN_LIMIT  = 4000;
  localparam logic [SIG_W-1:0] SIG_INT_BIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [4:0]        opc;
    logic [PTR_W-1:0]  idx;
    logic [SIG_W-1:0]  sig;
    logic [SE_W-1:0]   se;
    logic [WORD_W-1:0] word;
  } stack_req_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_COIN} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   outstanding;
  int   burst_left = 0;

  // weights for opcodes init..clex, the last one for the unused opcodes
  int op_weight [20] = '{1, 20, 8, 5, 5, 4, 3, 3, 8, 8, 5, 6, 3, 3, 8, 2, 2, 3, 2, 1};
  logic [ENTRY_W-1:0] value_pool [8] = '{default: '0};

  fru_in_if  req_ch ();
  fru_out_if rsp_ch ();

  float_register_stack_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fru_stack_checker stack_chk (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_ch.valid),
    .req_ready    (req_ch.ready),
    .req_opcode   (req_ch.opcode),
    .req_index    (req_ch.index),
    .req_sig      (req_ch.value_significand),
    .req_se       (req_ch.value_sign_exp),
    .req_word     (req_ch.word_value),
    .rsp_valid    (rsp_ch.valid),
    .rsp_ready    (rsp_ch.ready),
    .rsp_sig      (rsp_ch.out_significand),
    .rsp_se       (rsp_ch.out_sign_exp),
    .rsp_tag      (rsp_ch.out_tag),
    .rsp_status   (rsp_ch.status_out),
    .rsp_tag_word (rsp_ch.tag_word_out),
    .rsp_flags    (rsp_ch.compare_flags),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  always #5 clk = ~clk;

  function automatic stack_req_t mk(input logic [4:0] opc, input logic [PTR_W-1:0] idx,
                                    input logic [SIG_W-1:0] sig, input logic [SE_W-1:0] se,
                                    input logic [WORD_W-1:0] word);
    stack_req_t it;
    it.opc  = opc;
    it.idx  = idx;
    it.sig  = sig;
    it.se   = se;
    it.word = word;
    return it;
  endfunction

  // push operands spread over the value classes; reused values make equal compares likely
  function automatic logic [ENTRY_W-1:0] shaped_value();
    logic [SIG_W-1:0]   sig;
    logic [SE_W-1:0]    se;
    logic [ENTRY_W-1:0] v;
    sig = {$urandom, $urandom};
    se  = SE_W'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        sig = '0;
        se  = se & SIGN_BIT;
      end
      1: begin
        sig = sig & ~FRAC_MASK;
        se  = se | EXP_MASK;
      end
      2: begin
        sig[$urandom_range(0, 62)] = 1'b1;
        se = se | EXP_MASK;
      end
      3: begin
        sig[$urandom_range(0, 63)] = 1'b1;
        se = se & SIGN_BIT;
      end
      4, 5, 6: begin
        se[SE_W-2:0] = 15'(16'h3FFE + $urandom_range(0, 2));
        sig[SIG_W-1] = 1'b1;
      end
      7: begin
        se[SE_W-2:0] = 15'($urandom_range(1, 16'h7FFE));
        sig[SIG_W-1] = 1'b1;
      end
      8: begin
        v   = value_pool[$urandom_range(0, 7)];
        sig = v[SIG_W-1:0];
        se  = v[ENTRY_W-1:SIG_W] ^ (($urandom_range(0, 1) == 1) ? SIGN_BIT : 16'h0000);
      end
      default: ;
    endcase
    value_pool[$urandom_range(0, 7)] = {se, sig};
    return {se, sig};
  endfunction

  function automatic stack_req_t random_req();
    stack_req_t         it;
    logic [ENTRY_W-1:0] v;
    int                 pick;
    int                 code;
    it.idx  = PTR_W'($urandom);
    it.sig  = {$urandom, $urandom};
    it.se   = SE_W'($urandom);
    it.word = WORD_W'($urandom);
    pick = $urandom_range(0, 99);
    code = 0;
    while (pick >= op_weight[code]) begin
      pick -= op_weight[code];
      code++;
    end
    if (code > OP_CLEX) begin
      it.opc = 5'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else begin
      it.opc = code[4:0];
    end
    if (it.opc == OP_PUSH) begin
      v     = shaped_value();
      it.se  = v[ENTRY_W-1:SIG_W];
      it.sig = v[SIG_W-1:0];
    end
    // all tags valid so that the classes show through
    if (it.opc == OP_WTAG && $urandom_range(0, 2) == 0) begin
      it.word = '0;
    end
    return it;
  endfunction

  task automatic feed(input stack_req_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    req_ch.valid             <= 1'b1;
    req_ch.opcode            <= it.opc;
    req_ch.index             <= it.idx;
    req_ch.value_significand <= it.sig;
    req_ch.value_sign_exp    <= it.se;
    req_ch.word_value        <= it.word;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_quiet();
    int waited;
    req_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    burst_left = 0;
  endtask

  // result side stall pattern, starting open, then in modes picked at random
  initial begin : rx_side
    int       rx_cycle;
    rx_mode_t rx_mode;
    rx_cycle = 0;
    rx_mode  = RX_OPEN;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 150 == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end
      case (rx_mode)
        RX_OPEN:     rsp_ch.ready <= 1'b1;
        RX_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: rsp_ch.ready <= (rx_cycle % 7 >= 4);
        default:     rsp_ch.ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst                      <= 1'b1;
    req_ch.valid             <= 1'b0;
    req_ch.opcode            <= OP_WORDS;
    req_ch.index             <= '0;
    req_ch.value_significand <= '0;
    req_ch.value_sign_exp    <= '0;
    req_ch.word_value        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    feed(mk(OP_WORDS, 0, '0, '0, '0));
    feed(mk(OP_XAM, 0, '0, '0, '0));                          // empty st(0)
    feed(mk(OP_PUSH, 0, '1, 16'hFFFF, '0));                   // negative nan, all ones
    feed(mk(OP_PUSH, 7, '0, 16'h0000, 16'hFFFF));             // +0
    feed(mk(OP_PUSH, 0, '0, SIGN_BIT, '0));                   // -0
    feed(mk(OP_PUSH, 0, SIG_INT_BIT, EXP_MASK, '0));          // +inf
    feed(mk(OP_PUSH, 0, SIG_INT_BIT, 16'h3FFF, '0));          // 1.0
    feed(mk(OP_PUSH, 0, 64'hA000_0000_0000_0000, 16'hC000, '0));
    feed(mk(OP_COM, 1, '0, '0, '0));
    feed(mk(OP_COMI, 2, '0, '0, '0));                         // against infinity
    feed(mk(OP_COMI, 5, '0, '0, '0));                         // nan is unordered
    feed(mk(OP_COM, 7, '0, '0, '0));                          // empty is unordered
    feed(mk(OP_TST, 0, '0, '0, '0));
    feed(mk(OP_XCH, 3, '0, '0, '0));
    feed(mk(OP_COMI, 4, '0, '0, '0));                         // -0 against +0
    feed(mk(OP_XAM, 0, '0, '0, '0));
    feed(mk(OP_CHS, 0, '0, '0, '0));
    feed(mk(OP_ABS, 0, '0, '0, '0));
    feed(mk(OP_COPY, 6, '0, '0, '0));
    feed(mk(OP_READ, 6, '0, '0, '0));
    feed(mk(OP_FREE, 1, '0, '0, '0));
    feed(mk(OP_WSW, 7, '0, '0, 16'hFFFF));                    // top pointer from the word
    feed(mk(OP_CLEX, 0, '0, '0, '0));
    feed(mk(OP_WTAG, 0, '0, '0, 16'h0000));
    feed(mk(OP_INC, 2, '0, '0, '0));
    feed(mk(OP_DEC, 5, '0, '0, '0));
    feed(mk(OP_POP, 0, '0, '0, '0));
    feed(mk(OP_SPARE_HI, 3, '0, '0, '0));
    feed(mk(OP_INIT, 0, '0, '0, '0));
    feed(mk(OP_READ, 0, '0, '0, '0));                         // contents kept over init
    wait_quiet();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      feed(random_req());
      if (n == RANDOM_ITEMS / 2) begin
        wait_quiet();
      end
    end
    wait_quiet();
    repeat (8) @(posedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: float_register_stack_unit.f
rtl/core/fru_pkg.sv
rtl/core/fru_in_if.sv
rtl/core/fru_out_if.sv
rtl/core/fru_regfile.sv
rtl/core/fru_tagfile.sv
rtl/core/float_register_stack_unit.sv
rtl/core/fru_checker.sv
test/fru_stack_checker.sv
test/float_register_stack_unit_tb.sv
